@@ design/fcr_pkg.sv @@
// ----------------------------------------------------------------------------
// fcr_pkg: shared types and constants for the fingered chord recognizer
// Holds the chord shape table, action codes and the sequencer state type.
// ----------------------------------------------------------------------------
package fcr_pkg;

  localparam int NumKeys       = 128;
  localparam int KeyW          = 7;
  localparam int MinChordNotes = 2;
  localparam int MaxChordNotes = 6;
  localparam int CntW          = 3;

  typedef enum logic [1:0] {
    ACT_NOTE_ON  = 2'd0,
    ACT_NOTE_OFF = 2'd1,
    ACT_END      = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  localparam logic [1:0] POL_HOLD  = 2'd1;
  localparam logic [1:0] POL_NOTES = 2'd2;

  localparam logic [15:0] CancelMask = 16'h0007;

  typedef enum logic [1:0] {
    MT_NONE   = 2'd0,
    MT_CHORD  = 2'd1,
    MT_CANCEL = 2'd2
  } match_t;

  typedef struct packed {
    logic       hit;
    logic       cancel;
    logic [5:0] kind;
  } lookup_t;

  // Shape table lookup: mask -> chord kind (cancel shape flagged).
  function automatic lookup_t shape_lookup(input logic [15:0] m);
    lookup_t r;
    r.hit    = 1'b1;
    r.cancel = 1'b0;
    r.kind   = 6'd0;
    unique case (m)
      16'h0007: r.cancel = 1'b1;
      16'h000D, 16'h008D: r.kind = 6'd0;
      16'h0015, 16'h0095: r.kind = 6'd1;
      16'h0049: r.kind = 6'd2;
      16'h0051: r.kind = 6'd3;
      16'h0081: r.kind = 6'd4;
      16'h0085: r.kind = 6'd5;
      16'h0089: r.kind = 6'd6;
      16'h0091: r.kind = 6'd7;
      16'h00A1: r.kind = 6'd8;
      16'h00A9, 16'h00AD, 16'h04A9, 16'h04AD: r.kind = 6'd9;
      16'h0111: r.kind = 6'd10;
      16'h0215, 16'h0295: r.kind = 6'd11;
      16'h0249: r.kind = 6'd12;
      16'h0281, 16'h0291: r.kind = 6'd13;
      16'h0289: r.kind = 6'd14;
      16'h0409, 16'h0489: r.kind = 6'd15;
      16'h040D, 16'h048D: r.kind = 6'd16;
      16'h0411, 16'h0491: r.kind = 6'd17;
      16'h0413, 16'h0493: r.kind = 6'd18;
      16'h0415, 16'h0495: r.kind = 6'd19;
      16'h0419, 16'h0499: r.kind = 6'd20;
      16'h0421, 16'h04A1: r.kind = 6'd21;
      16'h0449: r.kind = 6'd22;
      16'h0451: r.kind = 6'd23;
      16'h0455, 16'h04D1, 16'h04D5: r.kind = 6'd24;
      16'h0511: r.kind = 6'd25;
      16'h0591: r.kind = 6'd26;
      16'h0611, 16'h0691: r.kind = 6'd27;
      16'h0809, 16'h0889: r.kind = 6'd28;
      16'h080D, 16'h088D: r.kind = 6'd29;
      16'h0811, 16'h0891: r.kind = 6'd30;
      16'h0815, 16'h0895: r.kind = 6'd31;
      16'h0849: r.kind = 6'd32;
      16'h0851: r.kind = 6'd33;
      16'h0855, 16'h08D1, 16'h08D5: r.kind = 6'd34;
      16'h0901, 16'h0911: r.kind = 6'd35;
      16'h1001: r.kind = 6'd36;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_MATCH = 7'b0000100,
    ST_OFF   = 7'b0001000,
    ST_ON    = 7'b0010000,
    ST_APPLY = 7'b0100000,
    ST_CLEAR = 7'b1000000
  } state_t;

endpackage

@@ design/fcr_key_scan.sv @@
// ----------------------------------------------------------------------------
// fcr_key_scan: held-key map with a sequential scan
// Walks the key map one key a cycle and collects up to six held notes.
// ----------------------------------------------------------------------------
module fcr_key_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [fcr_pkg::KeyW-1:0]   wr_key,
  input  logic                       wr_val,
  input  logic                       clr_all,
  input  logic                       scan_start,
  output logic                       scan_done,
  output logic                       too_many,
  output logic [fcr_pkg::CntW-1:0]   note_cnt,
  output logic [fcr_pkg::KeyW-1:0]   notes [fcr_pkg::MaxChordNotes]
);

  logic [fcr_pkg::NumKeys-1:0]  held_r;
  logic [fcr_pkg::KeyW-1:0]     idx_r;
  logic                         busy_r;
  logic                         over_r;
  logic [fcr_pkg::CntW-1:0]     cnt_r;
  logic [fcr_pkg::KeyW-1:0]     notes_r [fcr_pkg::MaxChordNotes];
  logic                         done_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      held_r <= '0;
    end else if (wr_en) begin
      held_r[wr_key] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
      cnt_r  <= '0;
      over_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (scan_start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
        cnt_r  <= '0;
        over_r <= 1'b0;
      end else if (busy_r) begin
        if (held_r[idx_r]) begin
          if (cnt_r == fcr_pkg::CntW'(fcr_pkg::MaxChordNotes)) begin
            over_r <= 1'b1;
          end else begin
            notes_r[cnt_r] <= idx_r;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        if (idx_r == fcr_pkg::KeyW'(fcr_pkg::NumKeys - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  assign scan_done = done_r;
  assign too_many  = over_r;
  assign note_cnt  = cnt_r;
  assign notes     = notes_r;

endmodule

@@ design/fcr_matcher.sv @@
// ----------------------------------------------------------------------------
// fcr_matcher: interval mask build and inversion search
// One diff/shift step per cycle, then one table lookup per inversion.
// ----------------------------------------------------------------------------
module fcr_matcher (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       too_many,
  input  logic [fcr_pkg::CntW-1:0]   note_cnt,
  input  logic [fcr_pkg::KeyW-1:0]   notes [fcr_pkg::MaxChordNotes],
  output logic                       done,
  output fcr_pkg::match_t            result,
  output logic [3:0]                 root,
  output logic [5:0]                 kind
);

  typedef enum logic [2:0] {
    MS_IDLE  = 3'b001,
    MS_BUILD = 3'b010,
    MS_LOOK  = 3'b100
  } mstate_t;

  mstate_t                  st_r;
  logic [fcr_pkg::CntW-1:0] i_r;
  logic [15:0]              mask_r;
  logic [5:0]               shift_r;
  logic [3:0]               diffs_r [fcr_pkg::MaxChordNotes];
  logic                     done_r;
  fcr_pkg::match_t          res_r;
  logic [3:0]               root_r;
  logic [5:0]               kind_r;

  logic [fcr_pkg::KeyW-1:0] d;
  logic [3:0]               dmod;
  logic [5:0]               sh_sum;
  fcr_pkg::lookup_t         lk;
  logic [16:0]              msum;
  logic [16:0]              mshift;
  logic [fcr_pkg::KeyW-1:0] nsel;
  logic [3:0]               nmod;

  // Mod 12 of a 7-bit difference: subtract the largest fitting multiple.
  always_comb begin
    d = notes[i_r] - notes[i_r - 1'b1];
    priority if (d >= 7'd120) dmod = 4'(d - 7'd120);
    else if (d >= 7'd108) dmod = 4'(d - 7'd108);
    else if (d >= 7'd96)  dmod = 4'(d - 7'd96);
    else if (d >= 7'd84)  dmod = 4'(d - 7'd84);
    else if (d >= 7'd72)  dmod = 4'(d - 7'd72);
    else if (d >= 7'd60)  dmod = 4'(d - 7'd60);
    else if (d >= 7'd48)  dmod = 4'(d - 7'd48);
    else if (d >= 7'd36)  dmod = 4'(d - 7'd36);
    else if (d >= 7'd24)  dmod = 4'(d - 7'd24);
    else if (d >= 7'd12)  dmod = 4'(d - 7'd12);
    else dmod = d[3:0];
    sh_sum = shift_r + 6'(dmod);
    lk     = fcr_pkg::shape_lookup(mask_r);
    msum   = {1'b0, mask_r} + 17'd4096;
    mshift = msum >> diffs_r[i_r];
    nsel   = notes[i_r];
    priority if (nsel >= 7'd120) nmod = 4'(nsel - 7'd120);
    else if (nsel >= 7'd108) nmod = 4'(nsel - 7'd108);
    else if (nsel >= 7'd96)  nmod = 4'(nsel - 7'd96);
    else if (nsel >= 7'd84)  nmod = 4'(nsel - 7'd84);
    else if (nsel >= 7'd72)  nmod = 4'(nsel - 7'd72);
    else if (nsel >= 7'd60)  nmod = 4'(nsel - 7'd60);
    else if (nsel >= 7'd48)  nmod = 4'(nsel - 7'd48);
    else if (nsel >= 7'd36)  nmod = 4'(nsel - 7'd36);
    else if (nsel >= 7'd24)  nmod = 4'(nsel - 7'd24);
    else if (nsel >= 7'd12)  nmod = 4'(nsel - 7'd12);
    else nmod = nsel[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MS_IDLE;
      done_r <= 1'b0;
      res_r  <= fcr_pkg::MT_NONE;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        MS_IDLE: begin
          if (start) begin
            if (too_many || note_cnt < fcr_pkg::CntW'(fcr_pkg::MinChordNotes)) begin
              res_r  <= fcr_pkg::MT_NONE;
              done_r <= 1'b1;
            end else begin
              st_r    <= MS_BUILD;
              i_r     <= fcr_pkg::CntW'(1);
              mask_r  <= 16'h0001;
              shift_r <= '0;
            end
          end
        end
        MS_BUILD: begin
          diffs_r[i_r - 1'b1] <= dmod;
          shift_r <= sh_sum;
          if (sh_sum < 6'd16) mask_r <= mask_r | (16'h0001 << sh_sum[3:0]);
          if (i_r + 1'b1 == note_cnt) begin
            st_r <= MS_LOOK;
            i_r  <= '0;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        MS_LOOK: begin
          if (lk.hit && lk.cancel) begin
            res_r <= fcr_pkg::MT_CANCEL;
            st_r <= MS_IDLE;
            done_r <= 1'b1;
          end else if (lk.hit) begin
            res_r  <= fcr_pkg::MT_CHORD;
            root_r <= nmod;
            kind_r <= lk.kind;
            st_r <= MS_IDLE;
            done_r <= 1'b1;
          end else if (i_r + 1'b1 == note_cnt) begin
            res_r <= fcr_pkg::MT_NONE;
            st_r <= MS_IDLE;
            done_r <= 1'b1;
          end else begin
            mask_r <= mshift[15:0];
            i_r <= i_r + 1'b1;
          end
        end
        default: st_r <= MS_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = res_r;
  assign root   = root_r;
  assign kind   = kind_r;

endmodule

@@ design/fingered_chord_recognizer.sv @@
// ----------------------------------------------------------------------------
// fingered_chord_recognizer: top level
// Tracks held keys, recognizes fingered chords and emits chord on/off events.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | action, pitch, time_delta
//  out_    | output    | out_valid/stall  | event_kind, elapsed_ticks,
//          |           |                  | root_class, chord_kind, last
//  cfg_    | input     | cfg_valid/ready  | sustain_policy (data)
//
// An item with a nonzero delta scans all 128 keys (one key per cycle in the
// key scanner), then builds the interval mask and tries inversions one per
// cycle. Zero-delta items go straight to the apply state; end of stream goes
// to the clear state, which first emits a chord off if one is active.
// Each result transaction waits in the output register until taken; in_stall
// stays high while the next one waits. Reset (rst_n low, synchronous) clears
// all chord state and the policy.
// ----------------------------------------------------------------------------
module fingered_chord_recognizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [6:0]  in_pitch,
  input  logic [15:0] in_time_delta,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_event_kind,
  output logic [31:0] out_elapsed_ticks,
  output logic [3:0]  out_root_class,
  output logic [5:0]  out_chord_kind,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_sustain_policy
);

  fcr_pkg::state_t st_r, st_nxt;

  logic [1:0]  pol_r;
  logic [1:0]  act_r;
  logic [6:0]  pitch_r;
  logic [15:0] delta_r;
  logic        active_r;
  logic [3:0]  cur_root_r;
  logic [5:0]  cur_kind_r;
  logic [31:0] ticks_r;
  logic        on_pend_r;

  logic        ov_r;
  logic        o_kind_r;
  logic [31:0] o_ticks_r;
  logic [3:0]  o_root_r;
  logic [5:0]  o_ckind_r;
  logic        o_last_r;

  logic        scan_start, scan_done, too_many;
  logic [fcr_pkg::CntW-1:0] note_cnt;
  logic [fcr_pkg::KeyW-1:0] notes [fcr_pkg::MaxChordNotes];
  logic        m_done;
  fcr_pkg::match_t m_res;
  logic [3:0]  m_root;
  logic [5:0]  m_kind;
  logic        key_wr, clr_all;
  logic        in_acc;
  logic        out_free;
  logic        o_load;
  logic        differs, do_off;
  logic [32:0] tsum;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (st_r != fcr_pkg::ST_IDLE);
  assign cfg_ready = (st_r == fcr_pkg::ST_IDLE);
  assign out_free  = !ov_r || !out_stall;

  // A new result transaction enters the output register this cycle.
  assign o_load = out_free && ((st_r == fcr_pkg::ST_OFF) || (st_r == fcr_pkg::ST_ON) ||
                               ((st_r == fcr_pkg::ST_CLEAR) && active_r));

  fcr_key_scan u_scan (
    .clk(clk), .rst_n(rst_n),
    .wr_en(key_wr), .wr_key(pitch_r), .wr_val(act_r == fcr_pkg::ACT_NOTE_ON),
    .clr_all(clr_all), .scan_start(scan_start), .scan_done(scan_done),
    .too_many(too_many), .note_cnt(note_cnt), .notes(notes)
  );

  fcr_matcher u_match (
    .clk(clk), .rst_n(rst_n), .start(scan_done), .too_many(too_many),
    .note_cnt(note_cnt), .notes(notes), .done(m_done), .result(m_res),
    .root(m_root), .kind(m_kind)
  );

  // Decision made once the matcher result is in.
  assign differs = (m_res == fcr_pkg::MT_CHORD) &&
                   (!active_r || m_root != cur_root_r || m_kind != cur_kind_r);
  assign do_off  = active_r && (differs ||
                   (m_res == fcr_pkg::MT_CANCEL && pol_r == fcr_pkg::POL_HOLD) ||
                   (m_res == fcr_pkg::MT_NONE && pol_r == fcr_pkg::POL_NOTES));
  assign tsum    = {1'b0, ticks_r} + 33'(delta_r);

  assign scan_start = in_acc && in_action != fcr_pkg::ACT_END &&
                      in_action != fcr_pkg::ACT_NONE && in_time_delta != 16'd0;
  assign key_wr  = (st_r == fcr_pkg::ST_APPLY) && out_free;
  assign clr_all = (st_r == fcr_pkg::ST_CLEAR) && out_free && !active_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      fcr_pkg::ST_IDLE: begin
        if (in_acc) begin
          priority if (in_action == fcr_pkg::ACT_NONE) st_nxt = fcr_pkg::ST_IDLE;
          else if (in_action == fcr_pkg::ACT_END) st_nxt = fcr_pkg::ST_CLEAR;
          else if (in_time_delta != 16'd0) st_nxt = fcr_pkg::ST_SCAN;
          else st_nxt = fcr_pkg::ST_APPLY;
        end
      end
      fcr_pkg::ST_SCAN:  if (m_done) st_nxt = fcr_pkg::ST_MATCH;
      fcr_pkg::ST_MATCH: begin
        priority if (do_off) st_nxt = fcr_pkg::ST_OFF;
        else if (differs) st_nxt = fcr_pkg::ST_ON;
        else st_nxt = fcr_pkg::ST_APPLY;
      end
      fcr_pkg::ST_OFF:   if (out_free) st_nxt = on_pend_r ? fcr_pkg::ST_ON : fcr_pkg::ST_APPLY;
      fcr_pkg::ST_ON:    if (out_free) st_nxt = fcr_pkg::ST_APPLY;
      fcr_pkg::ST_APPLY: if (out_free) st_nxt = fcr_pkg::ST_IDLE;
      fcr_pkg::ST_CLEAR: if (out_free && !active_r) st_nxt = fcr_pkg::ST_IDLE;
      default: st_nxt = fcr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= fcr_pkg::ST_IDLE;
      pol_r      <= '0;
      active_r   <= 1'b0;
      cur_root_r <= '0;
      cur_kind_r <= '0;
      ticks_r    <= '0;
      ov_r       <= 1'b0;
      on_pend_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (o_load) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
      if (cfg_valid && cfg_ready) pol_r <= cfg_sustain_policy;
      if (in_acc) begin
        act_r   <= in_action;
        pitch_r <= in_pitch;
        delta_r <= in_time_delta;
      end
      unique case (st_r)
        fcr_pkg::ST_MATCH: on_pend_r <= differs;
        fcr_pkg::ST_OFF: begin
          if (out_free) begin
            o_kind_r  <= 1'b0;
            o_ticks_r <= ticks_r;
            o_root_r  <= '0;
            o_ckind_r <= '0;
            o_last_r  <= !on_pend_r;
            active_r  <= 1'b0;
            ticks_r   <= '0;
          end
        end
        fcr_pkg::ST_ON: begin
          // Ticks were zeroed by a preceding chord off, if there was one.
          if (out_free) begin
            o_kind_r   <= 1'b1;
            o_ticks_r  <= ticks_r;
            o_root_r   <= m_root;
            o_ckind_r  <= m_kind;
            o_last_r   <= 1'b1;
            active_r   <= 1'b1;
            cur_root_r <= m_root;
            cur_kind_r <= m_kind;
            ticks_r    <= '0;
          end
        end
        fcr_pkg::ST_APPLY: begin
          if (out_free) ticks_r <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
        end
        fcr_pkg::ST_CLEAR: begin
          if (out_free) begin
            if (active_r) begin
              o_kind_r  <= 1'b0;
              o_ticks_r <= ticks_r;
              o_root_r  <= '0;
              o_ckind_r <= '0;
              o_last_r  <= 1'b1;
              active_r  <= 1'b0;
            end else begin
              cur_root_r <= '0;
              cur_kind_r <= '0;
              ticks_r    <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = ov_r;
  assign out_event_kind    = o_kind_r;
  assign out_elapsed_ticks = o_ticks_r;
  assign out_root_class    = o_root_r;
  assign out_chord_kind    = o_ckind_r;
  assign out_last          = o_last_r;

endmodule

@@ test/tb_fingered_chord_recognizer.sv @@
// ----------------------------------------------------------------------------
// tb_fingered_chord_recognizer: self-checking bench for the chord recognizer
// Drives note on/off and end-of-stream transactions with random gaps. A local
// model of the key map, the shape table and the sustain policy predicts every
// chord on/off transaction. Results are compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_fingered_chord_recognizer;

  localparam int NumShapes  = 62;
  localparam logic [5:0] KindCancel = 6'd63;
  localparam int CycleLimit = 2000000;
  localparam int SettleCycles = 300;

  // Shape table: interval mask -> chord type (cancel shape first).
  localparam logic [15:0] ShapeMask [NumShapes] = '{
    16'h0007, 16'h000D, 16'h0015, 16'h0049, 16'h0051, 16'h0081, 16'h0085,
    16'h0089, 16'h008D, 16'h0091, 16'h0095, 16'h00A1, 16'h00A9, 16'h00AD,
    16'h0111, 16'h0215, 16'h0249, 16'h0281, 16'h0289, 16'h0291, 16'h0295,
    16'h0409, 16'h040D, 16'h0411, 16'h0413, 16'h0415, 16'h0419, 16'h0421,
    16'h0449, 16'h0451, 16'h0455, 16'h0489, 16'h048D, 16'h0491, 16'h0493,
    16'h0495, 16'h0499, 16'h04A1, 16'h04A9, 16'h04AD, 16'h04D1, 16'h04D5,
    16'h0511, 16'h0591, 16'h0611, 16'h0691, 16'h0809, 16'h080D, 16'h0811,
    16'h0815, 16'h0849, 16'h0851, 16'h0855, 16'h0889, 16'h088D, 16'h0891,
    16'h0895, 16'h08D1, 16'h08D5, 16'h0901, 16'h0911, 16'h1001};
  localparam logic [5:0] ShapeKind [NumShapes] = '{
    KindCancel, 6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd0, 6'd7, 6'd1,
    6'd8, 6'd9, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd13, 6'd11,
    6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
    6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd9, 6'd9, 6'd24,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32,
    6'd33, 6'd34, 6'd28, 6'd29, 6'd30, 6'd31, 6'd34, 6'd34, 6'd35, 6'd35,
    6'd36};

  localparam logic [1:0] POL_NEW_ONLY = 2'd0;
  localparam logic [1:0] POL_ALIAS    = 2'd3;

  typedef struct {
    logic        event_kind;
    logic [31:0] elapsed_ticks;
    logic [3:0]  root_class;
    logic [5:0]  chord_kind;
    logic        last;
  } chord_event_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [6:0]  in_pitch;
  logic [15:0] in_time_delta;
  logic        out_valid;
  logic        out_stall;
  logic        out_event_kind;
  logic [31:0] out_elapsed_ticks;
  logic [3:0]  out_root_class;
  logic [5:0]  out_chord_kind;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_sustain_policy;

  fingered_chord_recognizer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_pitch           (in_pitch),
    .in_time_delta      (in_time_delta),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_kind     (out_event_kind),
    .out_elapsed_ticks  (out_elapsed_ticks),
    .out_root_class     (out_root_class),
    .out_chord_kind     (out_chord_kind),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_sustain_policy (cfg_sustain_policy)
  );

  // Local copy of the block's state
  logic        keys_down [fcr_pkg::NumKeys];
  logic        chord_on_now;
  logic [3:0]  chord_root;
  logic [5:0]  chord_type;
  logic [31:0] tick_count;
  logic [1:0]  policy;

  chord_event_t pending_events[$];
  bit  failed = 1'b0;
  bit  calm;        // when set, neither side inserts gaps
  int  cycle_count = 0;
  int  items_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("fingered_chord_recognizer: mismatch");
      $finish;
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic void clear_model();
    foreach (keys_down[k]) keys_down[k] = 1'b0;
    chord_on_now = 1'b0;
    chord_root   = '0;
    chord_type   = '0;
    tick_count   = '0;
  endfunction

  // Match held keys against the shape table; 0 none, 1 chord, 2 cancel.
  function automatic int match_held_keys(output logic [3:0] root,
                                         output logic [5:0] kind);
    int notes [fcr_pkg::MaxChordNotes];
    int steps [fcr_pkg::MaxChordNotes];
    int cnt;
    int shift;
    logic [15:0] mask;
    logic [31:0] wide;
    int hit;
    cnt   = 0;
    shift = 0;
    mask  = 16'h0001;
    root  = '0;
    kind  = '0;
    for (int k = 0; k < fcr_pkg::NumKeys; k++) begin
      if (keys_down[k]) begin
        if (cnt >= fcr_pkg::MaxChordNotes) return 0;
        notes[cnt] = k;
        cnt++;
      end
    end
    if (cnt < fcr_pkg::MinChordNotes) return 0;
    for (int i = 1; i < cnt; i++) begin
      steps[i-1] = (notes[i] - notes[i-1]) % 12;
      shift += steps[i-1];
      if (shift < 16) mask[shift] = 1'b1;
    end
    for (int i = 0; i < cnt; i++) begin
      hit = -1;
      for (int s = 0; s < NumShapes; s++)
        if (ShapeMask[s] == mask && hit < 0) hit = s;
      if (hit >= 0) begin
        if (ShapeKind[hit] == KindCancel) return 2;
        root = 4'(notes[i] % 12);
        kind = ShapeKind[hit];
        return 1;
      end
      if (i + 1 < cnt) begin
        wide = (32'(mask) + 32'd4096) >> steps[i];
        mask = wide[15:0];
      end
    end
    return 0;
  endfunction

  function automatic void push_event(logic ev, logic [3:0] root, logic [5:0] kind);
    chord_event_t e;
    e.event_kind    = ev;
    e.elapsed_ticks = tick_count;
    e.root_class    = root;
    e.chord_kind    = kind;
    e.last          = 1'b0;
    pending_events.push_back(e);
  endfunction

  // Apply one accepted note transaction to the local state.
  function automatic void predict_chord_events(logic [1:0] act, logic [6:0] key,
                                               logic [15:0] delta);
    int found;
    int before_cnt;
    logic [3:0] root;
    logic [5:0] kind;
    logic differs;
    logic [32:0] sum;
    before_cnt = pending_events.size();
    if (act == fcr_pkg::ACT_NONE) return;
    if (act == fcr_pkg::ACT_END) begin
      if (chord_on_now) push_event(1'b0, '0, '0);
      clear_model();
    end else begin
      if (delta != 0) begin
        found   = match_held_keys(root, kind);
        differs = (found == 1) &&
                  (!chord_on_now || root != chord_root || kind != chord_type);
        if (chord_on_now && (differs || (found == 2 && policy == fcr_pkg::POL_HOLD) ||
                             (found == 0 && policy == fcr_pkg::POL_NOTES))) begin
          push_event(1'b0, '0, '0);
          chord_on_now = 1'b0;
          tick_count   = '0;
        end
        if (differs) begin
          push_event(1'b1, root, kind);
          chord_on_now = 1'b1;
          chord_root   = root;
          chord_type   = kind;
          tick_count   = '0;
        end
      end
      sum = 33'(tick_count) + 33'(delta);
      tick_count = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      keys_down[key] = (act == fcr_pkg::ACT_NOTE_ON);
    end
    if (pending_events.size() > before_cnt)
      pending_events[pending_events.size()-1].last = 1'b1;
  endfunction

  // Result side: random stall, then compare with the oldest expectation.
  initial begin
    int wait_n;
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      wait_n = draw_gap();
      out_stall = (wait_n != 0);
      repeat (wait_n) @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  always @(posedge clk) begin
    chord_event_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("unexpected chord event transaction");
        failed = 1'b1;
      end else begin
        e = pending_events.pop_front();
        if (out_event_kind !== e.event_kind) begin
          $error("event_kind expected %0d actual %0d", e.event_kind, out_event_kind);
          failed = 1'b1;
        end
        if (out_elapsed_ticks !== e.elapsed_ticks) begin
          $error("elapsed_ticks expected %0d actual %0d", e.elapsed_ticks,
                 out_elapsed_ticks);
          failed = 1'b1;
        end
        if (out_root_class !== e.root_class) begin
          $error("root_class expected %0d actual %0d", e.root_class, out_root_class);
          failed = 1'b1;
        end
        if (out_chord_kind !== e.chord_kind) begin
          $error("chord_kind expected %0d actual %0d", e.chord_kind, out_chord_kind);
          failed = 1'b1;
        end
        if (out_last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, out_last);
          failed = 1'b1;
        end
      end
    end
  end

  // Send one note transaction; valid stays up across back-to-back items.
  task automatic send_note(logic [1:0] act, logic [6:0] key, logic [15:0] delta);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action     = act;
    in_pitch      = key;
    in_time_delta = delta;
    in_valid      = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_chord_events(act, key, delta);
    items_sent++;
  endtask

  // Drain all results; the block may still be busy on a silent item.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_policy(logic [1:0] value);
    wait_idle();
    cfg_sustain_policy = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    policy = value;
  endtask

  function automatic logic [15:0] draw_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 16'd0;
    if (r < 75) return 16'($urandom_range(1, 40));
    if (r < 85) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Release every held key, then press a table shape with a random
  // inversion and transpose, then trigger recognition with a nonzero delta.
  task automatic play_shape(int shape_idx, int base_key, int raised);
    int offs [16];
    int cnt;
    int key;
    cnt = 0;
    for (int b = 0; b < 16; b++)
      if (ShapeMask[shape_idx][b]) begin
        offs[cnt] = b;
        cnt++;
      end
    for (int k = 0; k < fcr_pkg::NumKeys; k++)
      if (keys_down[k]) send_note(fcr_pkg::ACT_NOTE_OFF, 7'(k), 16'd0);
    for (int j = 0; j < cnt; j++) begin
      key = base_key + offs[j] + ((j < raised) ? 12 : 0);
      if (key < fcr_pkg::NumKeys)
        send_note(fcr_pkg::ACT_NOTE_ON, 7'(key),
                  ($urandom_range(0, 5) == 0) ? draw_delta() : 16'd0);
    end
    send_note(fcr_pkg::ACT_NOTE_ON, 7'(base_key), 16'($urandom_range(1, 65535)));
  endtask

  // Directed: pitch and delta extremes, repeated note on, unmatched off.
  task automatic test_extremes();
    calm = 1'b1;
    send_note(fcr_pkg::ACT_NOTE_ON, 7'd0, 16'd0);
    send_note(fcr_pkg::ACT_NOTE_ON, 7'd4, 16'd0);
    send_note(fcr_pkg::ACT_NOTE_ON, 7'd7, 16'd0);
    send_note(fcr_pkg::ACT_NOTE_ON, 7'd4, 16'd0);       // repeated note on
    send_note(fcr_pkg::ACT_NOTE_OFF, 7'd90, 16'hFFFF);  // unmatched off, triggers chord
    send_note(fcr_pkg::ACT_NOTE_OFF, 7'd0, 16'hFFFF);
    send_note(fcr_pkg::ACT_NOTE_ON, 7'd127, 16'd1);
    send_note(fcr_pkg::ACT_NOTE_ON, 7'd120, 16'd1);
    send_note(fcr_pkg::ACT_NONE, 7'd127, 16'hFFFF);     // unused action
    send_note(fcr_pkg::ACT_NOTE_OFF, 7'd127, 16'd2);
    send_note(fcr_pkg::ACT_END, 7'd55, 16'hFFFF);
    send_note(fcr_pkg::ACT_END, 7'd0, 16'd0);           // end with nothing active
    calm = 1'b0;
  endtask

  // Cancel shape and no-chord under one policy.
  task automatic test_cancel_and_release();
    send_note(fcr_pkg::ACT_NOTE_ON, 7'd60, 16'd0);
    send_note(fcr_pkg::ACT_NOTE_ON, 7'd64, 16'd0);
    send_note(fcr_pkg::ACT_NOTE_ON, 7'd67, 16'd0);
    send_note(fcr_pkg::ACT_NOTE_OFF, 7'd67, 16'd10);    // C major on
    send_note(fcr_pkg::ACT_NOTE_ON, 7'd61, 16'd0);
    send_note(fcr_pkg::ACT_NOTE_ON, 7'd62, 16'd0);
    send_note(fcr_pkg::ACT_NOTE_OFF, 7'd64, 16'd0);
    send_note(fcr_pkg::ACT_NOTE_ON, 7'd30, 16'd7);      // 60,61,62: cancel shape
    send_note(fcr_pkg::ACT_NOTE_OFF, 7'd30, 16'd0);
    send_note(fcr_pkg::ACT_NOTE_OFF, 7'd61, 16'd0);
    send_note(fcr_pkg::ACT_NOTE_OFF, 7'd62, 16'd3);     // 60 and 62 held: no chord
    send_note(fcr_pkg::ACT_NOTE_OFF, 7'd60, 16'd3);
    send_note(fcr_pkg::ACT_END, 7'd0, 16'd0);
  endtask

  task automatic test_end_of_stream();
    play_shape(1, 48, 1);
    send_note(fcr_pkg::ACT_END, 7'd127, 16'd9);
    play_shape(41, 100, 0);                             // six-note shape
    send_note(fcr_pkg::ACT_NOTE_ON, 7'd2, 16'd0);       // seven keys: too many
    send_note(fcr_pkg::ACT_NOTE_ON, 7'd3, 16'd5);
    send_note(fcr_pkg::ACT_END, 7'd0, 16'd0);
  endtask

  // Mostly musical phrases, with noise and broken sequences between them.
  task automatic test_random_phrases(int count);
    int start;
    int r;
    start = items_sent;
    while (items_sent - start < count) begin
      calm = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        play_shape($urandom_range(0, NumShapes - 1), $urandom_range(0, 115),
                   $urandom_range(0, 3));
      end else if (r < 95) begin
        send_note(2'($urandom_range(0, 1)), 7'($urandom_range(0, 127)), draw_delta());
      end else begin
        send_note(2'($urandom_range(2, 3)), 7'($urandom_range(0, 127)), draw_delta());
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    calm        = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = fcr_pkg::ACT_NOTE_ON;
    in_pitch    = '0;
    in_time_delta = '0;
    cfg_valid   = 1'b0;
    cfg_sustain_policy = POL_NEW_ONLY;
    policy      = POL_NEW_ONLY;
    clear_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_cancel_and_release();
    write_policy(fcr_pkg::POL_HOLD);
    test_cancel_and_release();
    write_policy(fcr_pkg::POL_NOTES);
    test_cancel_and_release();
    test_end_of_stream();
    write_policy(POL_ALIAS);
    test_cancel_and_release();

    write_policy(POL_NEW_ONLY);
    test_random_phrases(500);
    write_policy(fcr_pkg::POL_HOLD);
    test_random_phrases(500);
    write_policy(fcr_pkg::POL_NOTES);
    test_random_phrases(500);
    write_policy(POL_ALIAS);
    test_random_phrases(400);

    wait_idle();
    if (!failed && pending_events.size() == 0) begin
      $display("fingered_chord_recognizer: match");
    end else begin
      $display("fingered_chord_recognizer: mismatch");
    end
    $finish;
  end

endmodule
